[src/assert_macros.svh]
// Assertion macros shared by the walker RTL.
// Each macro takes a label, a clock, an active-low reset, an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle assertion failed");

`endif

[src/sv39ptw_pkg.sv]
// Package for the Sv39 page-table walker: widths, codes and the result type.
// No dependencies; used by the channel interfaces and all walker modules.
package sv39ptw_pkg;

	localparam int LEVELS  = 3;
	localparam int LEVEL_W = 2;
	localparam int OFF_W   = 12;
	localparam int VPN_W   = 9;
	localparam int VA_BITS = OFF_W + VPN_W * LEVELS;
	localparam int PPN_W   = 44;
	localparam int ADDR_W  = 64;
	localparam int PTE_W   = 64;
	localparam int ACC_W   = 2;
	localparam int MF_W    = 4;
	localparam int ST_W    = 3;
	localparam int CFG_IDX_W = 1;
	localparam int PTE_PPN_LSB = 10;

	localparam logic KIND_TRANSLATE = 1'b0;
	localparam logic KIND_PTE_RESP  = 1'b1;

	localparam logic OUT_MEM_READ = 1'b0;
	localparam logic OUT_FINISHED = 1'b1;

	localparam logic [ACC_W-1:0] ACC_FETCH = 2'd0;
	localparam logic [ACC_W-1:0] ACC_LOAD  = 2'd1;
	localparam logic [ACC_W-1:0] ACC_STORE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_PAGING_ENABLE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROOT_PPN      = 1'b1;

	typedef enum logic [ST_W-1:0] {
		ST_OK          = 3'd0,
		ST_FETCH_FAULT = 3'd1,
		ST_LOAD_FAULT  = 3'd2,
		ST_STORE_FAULT = 3'd3,
		ST_MEM_ERROR   = 3'd4
	} status_t;

	typedef struct packed {
		logic              out_kind;
		logic [ADDR_W-1:0] address;
		status_t           status;
		logic [MF_W-1:0]   passed_fault;
	} result_t;

endpackage

[src/sv39ptw_req_if.sv]
// Input channel of the walker: translate requests and PTE read responses.
// Depends on sv39ptw_pkg for the field widths.
interface sv39ptw_req_if;
	import sv39ptw_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic [ADDR_W-1:0] vaddr;
	logic [ACC_W-1:0]  access_type;
	logic [PTE_W-1:0]  pte_word;
	logic [MF_W-1:0]   mem_fault;

	modport source (output valid, kind, vaddr, access_type, pte_word, mem_fault, input ready);
	modport sink (input valid, kind, vaddr, access_type, pte_word, mem_fault, output ready);
endinterface

[src/sv39ptw_rsp_if.sv]
// Output channel of the walker: PTE read requests and finished translations.
// Depends on sv39ptw_pkg for the field widths.
interface sv39ptw_rsp_if;
	import sv39ptw_pkg::*;

	logic              valid;
	logic              ready;
	logic              out_kind;
	logic [ADDR_W-1:0] address;
	logic [ST_W-1:0]   status;
	logic [MF_W-1:0]   passed_fault;

	modport source (output valid, out_kind, address, status, passed_fault, input ready);
	modport sink (input valid, out_kind, address, status, passed_fault, output ready);
endinterface

[src/sv39ptw_out_skid.sv]
// Two-entry output stage of the walker: an output register backed by a skid register.
// Depends on sv39ptw_pkg and the sv39ptw_rsp_if interface.
module sv39ptw_out_skid (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	input  sv39ptw_pkg::result_t push_data,
	output logic                 push_ready,
	sv39ptw_rsp_if.source        rsp
);
	import sv39ptw_pkg::*;

	logic    out_valid_q;
	result_t out_data_q;
	logic    skid_valid_q;
	result_t skid_data_q;
	logic    slot_free;

	// The output slot frees up when it is empty or its transfer completes this cycle.
	assign slot_free  = !out_valid_q || rsp.ready;
	assign push_ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (slot_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push_valid;
			end
		end else if (push_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (push_valid) begin
				out_data_q <= push_data;
			end
		end else if (push_valid) begin
			skid_data_q <= push_data;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.out_kind     = out_data_q.out_kind;
	assign rsp.address      = out_data_q.address;
	assign rsp.status       = out_data_q.status;
	assign rsp.passed_fault = out_data_q.passed_fault;
endmodule

[src/sv39_page_table_walker_unit.sv]
// Sv39 page-table walker, top level.
// Each result is registered in the output register, or in the skid register while that is held, before rsp offers it.
// Throughput: one input item per cycle; a two-entry output stage keeps req ready while
// one result waits, so req stalls only when both entries are full.
// Reset (arst_n low): paging off, root PPN zero, walker idle at the top level, output empty.
// Depends on sv39ptw_pkg, sv39ptw_req_if, sv39ptw_rsp_if, sv39ptw_out_skid, assert_macros.svh.
`include "assert_macros.svh"

module sv39_page_table_walker_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	sv39ptw_req_if.sink                          req,
	sv39ptw_rsp_if.source                        rsp,
	input  logic                                 cfg_write_en,
	input  logic [sv39ptw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sv39ptw_pkg::PPN_W-1:0]        cfg_wdata
);
	import sv39ptw_pkg::*;

	localparam int PAD_W = ADDR_W - PPN_W - VPN_W - 3;
	localparam int PA_W  = PPN_W + OFF_W;

	logic               paging_enable_q;
	logic [PPN_W-1:0]   root_ppn_q;
	logic               walking_q;
	logic [LEVEL_W-1:0] level_q;
	logic [VA_BITS-1:0] saved_vaddr_q;
	logic [ACC_W-1:0]   fault_kind_q;

	logic               walking_d;
	logic [LEVEL_W-1:0] level_d;
	logic [VA_BITS-1:0] saved_vaddr_d;
	logic [ACC_W-1:0]   fault_kind_d;

	logic               req_acc;
	logic               is_translate;
	logic               res_valid;
	result_t            res;
	logic               push_ready;

	logic               pte_v;
	logic               pte_r;
	logic               pte_w;
	logic               pte_x;
	logic [PPN_W-1:0]   pte_ppn;
	logic [PPN_W-1:0]   read_ppn;
	logic [LEVEL_W-1:0] read_level;
	logic [VA_BITS-1:0] read_va;
	logic [VPN_W-1:0]   read_vpn;
	logic [ADDR_W-1:0]  read_addr;
	logic [PA_W-1:0]    keep_mask;
	logic [PA_W-1:0]    leaf_pa;
	status_t            fault_status;

	assign req.ready    = push_ready;
	assign req_acc      = req.valid && req.ready;
	assign is_translate = (req.kind == KIND_TRANSLATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paging_enable_q <= 1'b0;
			root_ppn_q      <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_PAGING_ENABLE: paging_enable_q <= cfg_wdata[0];
				CFG_ROOT_PPN:      root_ppn_q      <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign pte_v   = req.pte_word[0];
	assign pte_r   = req.pte_word[1];
	assign pte_w   = req.pte_word[2];
	assign pte_x   = req.pte_word[3];
	assign pte_ppn = req.pte_word[PTE_PPN_LSB +: PPN_W];

	// The next PTE read either starts at the root table or descends from a pointer PTE.
	assign read_ppn   = is_translate ? root_ppn_q : pte_ppn;
	assign read_level = is_translate ? LEVEL_W'(LEVELS - 1) : level_q - LEVEL_W'(1);
	assign read_va    = is_translate ? req.vaddr[VA_BITS-1:0] : saved_vaddr_q;
	assign read_vpn   = VPN_W'(read_va >> (OFF_W + VPN_W * int'(read_level)));
	assign read_addr  = {{PAD_W{1'b0}}, read_ppn, read_vpn, 3'b000};

	// A leaf keeps the offset bits below its page size from the virtual address.
	assign keep_mask = (PA_W'(1) << (OFF_W + VPN_W * int'(level_q))) - PA_W'(1);
	assign leaf_pa   = ({pte_ppn, {OFF_W{1'b0}}} & ~keep_mask)
		| (PA_W'(saved_vaddr_q) & keep_mask);

	always_comb begin
		unique case (fault_kind_q)
			ACC_FETCH: fault_status = ST_FETCH_FAULT;
			ACC_LOAD:  fault_status = ST_LOAD_FAULT;
			default:   fault_status = ST_STORE_FAULT;
		endcase
	end

	always_comb begin
		walking_d     = walking_q;
		level_d       = level_q;
		saved_vaddr_d = saved_vaddr_q;
		fault_kind_d  = fault_kind_q;
		res_valid     = 1'b0;
		res           = '{out_kind: OUT_FINISHED, address: '0, status: ST_OK, passed_fault: '0};
		if (req_acc) begin
			if (is_translate) begin
				res_valid = 1'b1;
				if (!paging_enable_q) begin
					walking_d   = 1'b0;
					res.address = req.vaddr;
				end else begin
					walking_d     = 1'b1;
					level_d       = read_level;
					saved_vaddr_d = read_va;
					fault_kind_d  = req.access_type[1] ? ACC_STORE : req.access_type;
					res.out_kind  = OUT_MEM_READ;
					res.address   = read_addr;
				end
			end else if (walking_q) begin
				res_valid = 1'b1;
				walking_d = 1'b0;
				if (req.mem_fault != '0) begin
					res.status       = ST_MEM_ERROR;
					res.passed_fault = req.mem_fault;
				end else if (!pte_v || (!pte_r && pte_w)) begin
					res.status = fault_status;
				end else if (pte_r || pte_x) begin
					res.address = ADDR_W'(leaf_pa);
				end else if (level_q == '0) begin
					res.status = fault_status;
				end else begin
					walking_d    = 1'b1;
					level_d      = read_level;
					res.out_kind = OUT_MEM_READ;
					res.address  = read_addr;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walking_q     <= 1'b0;
			level_q       <= LEVEL_W'(LEVELS - 1);
			saved_vaddr_q <= '0;
			fault_kind_q  <= ACC_FETCH;
		end else begin
			walking_q     <= walking_d;
			level_q       <= level_d;
			saved_vaddr_q <= saved_vaddr_d;
			fault_kind_q  <= fault_kind_d;
		end
	end

	sv39ptw_out_skid u_out_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (res_valid),
		.push_data  (res),
		.push_ready (push_ready),
		.rsp        (rsp)
	);

	`ASSERT_NEXT(a_result_offered, clk, arst_n, req_acc && (is_translate || walking_q), rsp.valid)
	`ASSERT_NEXT(a_idle_resp_ignored, clk, arst_n, req_acc && !is_translate && !walking_q, !walking_q)
	`ASSERT_NEXT(a_bypass_stays_idle, clk, arst_n, req_acc && is_translate && !paging_enable_q, !walking_q)
	`ASSERT_SAME(a_read_clean, clk, arst_n, rsp.valid && (rsp.out_kind == OUT_MEM_READ), (rsp.status == ST_OK) && (rsp.passed_fault == '0))
endmodule

[sim/tb.sv]
// Self-checking testbench for sv39_page_table_walker_unit: it plays both the requester and the
// page-table memory, predicts every PTE read and finished translation, and checks each transfer.
// Depends on sv39ptw_pkg, sv39ptw_req_if, sv39ptw_rsp_if and the walker RTL.
module tb;
	import sv39ptw_pkg::*;

	localparam int CYCLE_LIMIT  = 250000;
	localparam int DRAIN_CYCLES = 4;
	localparam int HOLD_CYCLES  = 300;

	localparam logic [ACC_W-1:0] ACC_RESERVED = 2'd3;
	localparam logic [PTE_W-1:0] PTE_WRITE    = 64'h4;

	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] vaddr;
		logic [ACC_W-1:0]  access_type;
		logic [PTE_W-1:0]  pte_word;
		logic [MF_W-1:0]   mem_fault;
	} walk_item_t;

	typedef enum int {SHAPE_POINTER, SHAPE_LEAF, SHAPE_BAD} pte_shape_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_write_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PPN_W-1:0] cfg_wdata;

	sv39ptw_req_if req_ch();
	sv39ptw_rsp_if rsp_ch();

	sv39_page_table_walker_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_ch),
		.rsp          (rsp_ch),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	// Predicted translation settings and walk state.
	bit                   sat_paging  = 1'b0;
	logic [PPN_W-1:0]     sat_root    = '0;
	bit                   walk_active = 1'b0;
	logic [LEVEL_W-1:0]   walk_level  = LEVEL_W'(LEVELS - 1);
	logic [OFF_W+PPN_W-1:0] walk_table = '0;
	logic [VA_BITS-1:0]   walk_va     = '0;
	logic [ACC_W-1:0]     walk_acc    = '0;

	result_t due_results[$];
	int      fail_count   = 0;
	int      results_sent = 0;
	int      cycle_count  = 0;
	bit      idling       = 1'b1;
	int      hold_len     = 0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sv39_page_table_walker_unit verification failed");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [ADDR_W-1:0] pte_read_addr();
		logic [VPN_W-1:0] vpn;
		vpn = VPN_W'(walk_va >> (OFF_W + VPN_W * walk_level));
		return {8'h00, walk_table} + {52'h0, vpn, 3'b000};
	endfunction

	function automatic status_t fault_status(input logic [ACC_W-1:0] acc);
		case (acc)
			ACC_FETCH: return ST_FETCH_FAULT;
			ACC_LOAD: return ST_LOAD_FAULT;
			default: return ST_STORE_FAULT;
		endcase
	endfunction

	function automatic bit walk_predict(input walk_item_t it, output result_t res);
		logic [PPN_W-1:0]  ppn;
		logic [ADDR_W-1:0] keep;
		logic              v, r, w, x;
		res = '0;
		ppn = it.pte_word[PTE_PPN_LSB +: PPN_W];
		{x, w, r, v} = it.pte_word[3:0];
		if (it.kind == KIND_TRANSLATE) begin
			walk_active = 1'b0;
			res.out_kind = OUT_FINISHED;
			res.address = it.vaddr;
			if (sat_paging) begin
				walk_acc = it.access_type;
				walk_va = it.vaddr[VA_BITS-1:0];
				walk_level = LEVEL_W'(LEVELS - 1);
				walk_table = {sat_root, {OFF_W{1'b0}}};
				walk_active = 1'b1;
				res.out_kind = OUT_MEM_READ;
				res.address = pte_read_addr();
			end
			return 1'b1;
		end
		if (!walk_active)
			return 1'b0;
		res.out_kind = OUT_FINISHED;
		walk_active = 1'b0;
		if (it.mem_fault != '0) begin
			res.status = ST_MEM_ERROR;
			res.passed_fault = it.mem_fault;
		end else if (!v || (w && !r)) begin
			res.status = fault_status(walk_acc);
		end else if (r || x) begin
			keep = (64'd1 << (OFF_W + VPN_W * walk_level)) - 64'd1;
			res.address = ({8'h00, ppn, {OFF_W{1'b0}}} & ~keep) | (ADDR_W'(walk_va) & keep);
		end else if (walk_level == 0) begin
			res.status = fault_status(walk_acc);
		end else begin
			walk_level = walk_level - LEVEL_W'(1);
			walk_table = {ppn, {OFF_W{1'b0}}};
			walk_active = 1'b1;
			res.out_kind = OUT_MEM_READ;
			res.address = pte_read_addr();
		end
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		result_t exp;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (due_results.size() == 0) begin
				$display("%0t: result expected none actual out_kind=%0h address=%0h status=%0h fault=%0h",
					$time, rsp_ch.out_kind, rsp_ch.address, rsp_ch.status, rsp_ch.passed_fault);
				fail_count++;
			end else begin
				exp = due_results.pop_front();
				check_field("out_kind", 64'(exp.out_kind), 64'(rsp_ch.out_kind));
				check_field("address", exp.address, rsp_ch.address);
				check_field("status", 64'(exp.status), 64'(rsp_ch.status));
				check_field("passed_fault", 64'(exp.passed_fault), 64'(rsp_ch.passed_fault));
			end
		end
	end

	initial begin : result_receiver
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_len != 0) begin
				hold_left = hold_len;
				hold_len = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (idling && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 14);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_item(input walk_item_t it);
		result_t res;
		@(negedge clk);
		req_ch.kind <= it.kind;
		req_ch.vaddr <= it.vaddr;
		req_ch.access_type <= it.access_type;
		req_ch.pte_word <= it.pte_word;
		req_ch.mem_fault <= it.mem_fault;
		req_ch.valid <= 1'b1;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		if (walk_predict(it, res)) begin
			due_results.push_back(res);
			results_sent++;
		end
		if (idling && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(0, 14)) @(negedge clk);
		end
	endtask

	task automatic send_translate(input logic [ADDR_W-1:0] va, input logic [ACC_W-1:0] acc);
		walk_item_t it;
		it.kind = KIND_TRANSLATE;
		it.vaddr = va;
		it.access_type = acc;
		it.pte_word = rand64();
		it.mem_fault = MF_W'($urandom);
		send_item(it);
	endtask

	task automatic send_pte(input logic [PTE_W-1:0] pte, input logic [MF_W-1:0] mf);
		walk_item_t it;
		it.kind = KIND_PTE_RESP;
		it.vaddr = rand64();
		it.access_type = ACC_W'($urandom);
		it.pte_word = pte;
		it.mem_fault = mf;
		send_item(it);
	endtask

	function automatic logic [PPN_W-1:0] rand_ppn();
		logic [63:0] bits;
		bits = rand64();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return bits[PPN_W-1:0];
		endcase
	endfunction

	function automatic logic [ADDR_W-1:0] rand_va();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return rand64();
		endcase
	endfunction

	// Flag bits above X and the bits above the PPN are left random.
	function automatic logic [PTE_W-1:0] make_pte(input pte_shape_t shape, input logic [PPN_W-1:0] ppn);
		logic [PTE_W-1:0] pte;
		logic [2:0]       xwr;
		logic             v;
		pte = rand64();
		pte[PTE_PPN_LSB +: PPN_W] = ppn;
		v = 1'b1;
		case (shape)
			SHAPE_POINTER: xwr = 3'b000;
			SHAPE_LEAF: begin
				do xwr = 3'($urandom_range(1, 7)); while (!xwr[0] && xwr[1]);
			end
			default: begin
				if ($urandom_range(0, 1) == 0) begin
					v = 1'b0;
					xwr = 3'($urandom);
				end else begin
					xwr = {1'($urandom), 2'b10};
				end
			end
		endcase
		pte[3:0] = {xwr, v};
		return pte;
	endfunction

	task automatic random_walk();
		int pick;
		int hops;
		int i;
		pick = $urandom_range(0, 99);
		hops = $urandom_range(0, LEVELS - 1);
		send_translate(rand_va(), ACC_W'($urandom_range(0, 3)));
		if (!sat_paging)
			return;
		if (pick >= 70 && pick < 78)
			hops = LEVELS;
		for (i = 0; i < hops; i++)
			send_pte(make_pte(SHAPE_POINTER, rand_ppn()), '0);
		if (pick < 55)
			send_pte(make_pte(SHAPE_LEAF, rand_ppn()), '0);
		else if (pick < 70)
			send_pte(make_pte(SHAPE_BAD, rand_ppn()), '0);
		else if (pick >= 78 && pick < 90)
			send_pte(rand64(), MF_W'($urandom_range(1, 15)));
		// Otherwise the walk is left open and the next request abandons it.
	endtask

	task automatic noise_item();
		walk_item_t it;
		it.kind = 1'($urandom);
		it.vaddr = rand64();
		it.access_type = ACC_W'($urandom);
		it.pte_word = rand64();
		it.mem_fault = ($urandom_range(0, 3) == 0) ? MF_W'($urandom) : '0;
		send_item(it);
	endtask

	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PPN_W-1:0] data);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		if (idx == CFG_PAGING_ENABLE)
			sat_paging = data[0];
		else
			sat_root = data;
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	task automatic reconfigure(input bit paging, input logic [PPN_W-1:0] root);
		logic [PPN_W-1:0] enable_word;
		enable_word = rand_ppn();
		enable_word[0] = paging;
		drain();
		write_reg(CFG_PAGING_ENABLE, enable_word);
		write_reg(CFG_ROOT_PPN, root);
	endtask

	task automatic run_until(input int count);
		int goal;
		goal = results_sent + count;
		while (results_sent < goal) begin
			if ($urandom_range(0, 9) == 0)
				noise_item();
			else
				random_walk();
		end
	endtask

	task automatic test_passthrough();
		send_translate('0, ACC_FETCH);
		send_translate('1, ACC_RESERVED);
		send_pte('1, '1);
	endtask

	task automatic test_directed_walks();
		reconfigure(1'b1, '1);
		send_translate('1, ACC_FETCH);
		send_pte('1, '0);
		send_translate('0, ACC_LOAD);
		send_pte(make_pte(SHAPE_POINTER, '0), '0);
		send_pte(make_pte(SHAPE_LEAF, '1), '0);
		send_translate(rand64(), ACC_STORE);
		send_pte(make_pte(SHAPE_POINTER, rand_ppn()), '0);
		send_pte(make_pte(SHAPE_POINTER, rand_ppn()), '0);
		send_pte(make_pte(SHAPE_LEAF, rand_ppn()), '0);
		send_translate(rand64(), ACC_RESERVED);
		send_pte('0, '0);
		send_translate(rand64(), ACC_LOAD);
		send_pte(make_pte(SHAPE_POINTER, rand_ppn()), '0);
		send_pte(make_pte(SHAPE_POINTER, rand_ppn()) | PTE_WRITE, '0);
		send_translate(rand64(), ACC_FETCH);
		repeat (LEVELS) send_pte(make_pte(SHAPE_POINTER, rand_ppn()), '0);
		send_translate(rand64(), ACC_LOAD);
		send_pte(rand64(), '1);
		send_translate(rand64(), ACC_STORE);
		send_pte(make_pte(SHAPE_POINTER, rand_ppn()), '0);
		send_translate(rand64(), ACC_FETCH);
		send_pte(make_pte(SHAPE_LEAF, rand_ppn()), '0);
		send_pte(rand64(), MF_W'($urandom));
	endtask

	task automatic test_config_sweep();
		reconfigure(1'b0, rand_ppn());
		repeat (20) random_walk();
		reconfigure(1'b1, '0);
		repeat (20) random_walk();
		reconfigure(1'b1, rand_ppn());
		repeat (20) random_walk();
	endtask

	task automatic test_random_walks();
		repeat (6) begin
			reconfigure($urandom_range(0, 4) != 0, rand_ppn());
			run_until(140);
		end
	endtask

	task automatic test_backpressure();
		reconfigure(1'b1, rand_ppn());
		@(posedge clk);
		hold_len = HOLD_CYCLES;
		repeat (30) random_walk();
	endtask

	task automatic test_final_burst();
		reconfigure(1'b1, rand_ppn());
		idling = 1'b0;
		run_until(150);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = CFG_PAGING_ENABLE;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_TRANSLATE;
		req_ch.vaddr = '0;
		req_ch.access_type = ACC_FETCH;
		req_ch.pte_word = '0;
		req_ch.mem_fault = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_passthrough();
		test_directed_walks();
		test_config_sweep();
		test_random_walks();
		test_backpressure();
		test_final_burst();

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("sv39_page_table_walker_unit verification clean");
		else
			$display("sv39_page_table_walker_unit verification failed");
		$finish;
	end
endmodule
